// ===== rtl/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Types and constants shared by the 3x3 RGB box filter modules.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int KERNEL       = 3;
  localparam int ROW_LIMIT    = 2048;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int CFG_W        = 12;
  localparam int POS_W        = 11;
  localparam int JQ_DEPTH     = 4;
  localparam int OF_DEPTH     = 8;

  // floor(s / 9) == (s * RECIP9) >> DIV9_SHIFT for every s up to 9 * 255
  localparam int RECIP9       = 7282;
  localparam int DIV9_SHIFT   = 16;

  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic             cfg_index_t;

  localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    pos_t       out_column;
    pos_t       out_row;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // one entry of the line store: rows r-2 and r-1 at one column
  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_pair_t;

  // sum of one window column (three pixels) per channel
  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } col_sum_t;

  // work handed from front to back: up to three results of one input
  typedef struct packed {
    logic     has_a;     // lagging result (c-1, r-1)
    logic     has_b;     // right edge of the row above (w-1, r-1)
    logic     has_c;     // bottom row pass-through (c, r)
    logic     filt;      // first result is an interior mean
    col_sum_t cs0;
    col_sum_t cs1;
    col_sum_t cs2;
    pixel_t   pass_a;
    pixel_t   pix_b;
    pixel_t   pix_c;
    pos_t     col;
    pos_t     row;
    pos_t     edge_col;
  } job_t;

endpackage

// ===== rtl/bf3_front.sv =====
// ----------------------------------------------------------------------------
// bf3_front
// Pixel intake: position counters, size registers, line store, window of
// column sums, and classification of the results each pixel causes.
// ----------------------------------------------------------------------------
module bf3_front
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  input  in_item_t   pixel_in,
  input  logic       push,
  output logic       full,
  output job_t       job,
  output logic       job_push,
  input  logic       job_full
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCMP = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int RESET_W_LAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

  logic [CW-1:0] col;
  pos_t          row;
  logic [CW-1:0] width_last;
  pos_t          height_last;
  logic [CW-1:0] width_last_next;
  pos_t          height_last_next;
  logic [WCMP-1:0] wreq;

  logic          s1_valid;
  pixel_t        s1_px;
  logic [CW-1:0] s1_col;
  pos_t          s1_row;
  line_pair_t    mem_q;
  line_pair_t    line_mem [MAX_WIDTH];

  col_sum_t      win_cs1;
  col_sum_t      win_cs2;
  pixel_t        win_mid;
  col_sum_t      cs_cur;

  logic          accept;
  logic          s1_go;
  logic          has_a;
  logic          has_b;
  logic          has_c;
  logic          any_res;

  // saturate requested sizes to the supported range, stored as size - 1
  always_comb begin
    wreq = WCMP'(cfg_data);
    if (wreq < WCMP'(KERNEL)) begin
      width_last_next = CW'(KERNEL - 1);
    end else if (wreq > WCMP'(MAX_WIDTH)) begin
      width_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      width_last_next = CW'(wreq - WCMP'(1));
    end
    if (cfg_data < CFG_W'(KERNEL)) begin
      height_last_next = POS_W'(KERNEL - 1);
    end else if (cfg_data > CFG_W'(ROW_LIMIT)) begin
      height_last_next = POS_W'(ROW_LIMIT - 1);
    end else begin
      height_last_next = POS_W'(cfg_data - CFG_W'(1));
    end
  end

  always_comb begin
    has_a   = (s1_row != '0) && (s1_col != '0);
    has_b   = (s1_row != '0) && (s1_col == width_last);
    has_c   = (s1_row == height_last);
    any_res = has_a || has_b || has_c;
    s1_go   = s1_valid && (!any_res || !job_full);
    full    = s1_valid && !s1_go;
    accept  = push && !full;
  end

  always_comb begin
    cs_cur.red   = 10'(mem_q.upper.red)   + 10'(mem_q.lower.red)   + 10'(s1_px.red);
    cs_cur.green = 10'(mem_q.upper.green) + 10'(mem_q.lower.green) + 10'(s1_px.green);
    cs_cur.blue  = 10'(mem_q.upper.blue)  + 10'(mem_q.lower.blue)  + 10'(s1_px.blue);
  end

  always_comb begin
    job_push     = s1_valid && any_res && !job_full;
    job.has_a    = has_a;
    job.has_b    = has_b;
    job.has_c    = has_c;
    job.filt     = (s1_col >= CW'(KERNEL - 1)) && (s1_row >= POS_W'(KERNEL - 1));
    job.cs0      = cs_cur;
    job.cs1      = win_cs1;
    job.cs2      = win_cs2;
    job.pass_a   = win_mid;
    job.pix_b    = mem_q.lower;
    job.pix_c    = s1_px;
    job.col      = POS_W'(s1_col);
    job.row      = s1_row;
    job.edge_col = POS_W'(width_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      width_last  <= CW'(RESET_W_LAST);
      height_last <= POS_W'(RESET_HEIGHT - 1);
      s1_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_last  <= width_last_next;
          REG_IMAGE_HEIGHT: height_last <= height_last_next;
        endcase
        // any register write restarts the frame
        col <= '0;
        row <= '0;
      end else if (accept) begin
        if (col == width_last) begin
          col <= '0;
          row <= (row == height_last) ? '0 : row + POS_W'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // line store: read on accept, write back the shifted pair when the pixel advances
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q  <= line_mem[col];
      s1_px  <= '{red: pixel_in.red_in, green: pixel_in.green_in, blue: pixel_in.blue_in};
      s1_col <= col;
      s1_row <= row;
    end
    if (s1_go) begin
      line_mem[s1_col] <= '{upper: mem_q.lower, lower: s1_px};
      win_cs1          <= cs_cur;
      win_cs2          <= win_cs1;
      win_mid          <= mem_q.lower;
    end
  end

endmodule

// ===== rtl/bf3_job_queue.sv =====
// ----------------------------------------------------------------------------
// bf3_job_queue
// Short queue of classified pixels between the intake and the result side.
// ----------------------------------------------------------------------------
module bf3_job_queue
  import bf3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  job_t wr_job,
  input  logic wr_push,
  output logic wr_full,
  output job_t rd_job,
  input  logic rd_pop,
  output logic rd_empty
);

  localparam int PW = $clog2(JQ_DEPTH);

  job_t          slots [JQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign wr_full  = (count == (PW + 1)'(JQ_DEPTH));
  assign rd_empty = (count == '0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW + 1)'(wr_push) - (PW + 1)'(rd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== rtl/bf3_back.sv =====
// ----------------------------------------------------------------------------
// bf3_back
// Result side: splits each job into its results, forms the 3x3 mean by a
// reciprocal multiply, and holds finished results in an output queue.
// ----------------------------------------------------------------------------
module bf3_back
  import bf3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  typedef enum logic [1:0] {
    RES_INNER,
    RES_EDGE,
    RES_BOTTOM
  } res_kind_t;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } win_sum_t;

  typedef struct packed {
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
  } prod_t;

  localparam int OW = $clog2(OF_DEPTH);

  logic      done_a;
  logic      done_b;
  logic      pend_a;
  logic      pend_b;
  res_kind_t kind;
  logic      sel_last;
  logic      space;
  logic      issue;

  logic      b1_valid;
  logic      b1_filt;
  win_sum_t  b1_sum;
  pixel_t    b1_pix;
  pos_t      b1_col;
  pos_t      b1_row;
  logic      b1_last;

  logic      b2_valid;
  logic      b2_filt;
  prod_t     b2_prod;
  pixel_t    b2_pix;
  pos_t      b2_col;
  pos_t      b2_row;
  logic      b2_last;

  out_item_t of_word;
  out_item_t of_slots [OF_DEPTH];
  logic [OW-1:0] of_wr;
  logic [OW-1:0] of_rd;
  logic [OW:0]   of_count;
  logic [OW+1:0] of_load;
  logic          of_pop;

  always_comb begin
    pend_a = job.has_a && !done_a;
    pend_b = job.has_b && !done_b;
    if (pend_a) begin
      kind     = RES_INNER;
      sel_last = !(pend_b || job.has_c);
    end else if (pend_b) begin
      kind     = RES_EDGE;
      sel_last = !job.has_c;
    end else begin
      kind     = RES_BOTTOM;
      sel_last = 1'b1;
    end
    // count results in flight so the output queue never overflows
    of_load = (OW + 2)'(of_count) + (OW + 2)'(b1_valid) + (OW + 2)'(b2_valid);
    space   = (of_load < (OW + 2)'(OF_DEPTH));
    issue   = !job_empty && space;
    job_pop = issue && sel_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_a   <= 1'b0;
      done_b   <= 1'b0;
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        done_a <= 1'b0;
        done_b <= 1'b0;
      end else if (issue) begin
        unique case (kind)
          RES_INNER:  done_a <= 1'b1;
          RES_EDGE:   done_b <= 1'b1;
          RES_BOTTOM: done_b <= done_b;
          default:    done_b <= done_b;
        endcase
      end
      b1_valid <= issue;
      b2_valid <= b1_valid;
    end
  end

  // stage 1: pick the result, add the three column sums
  always_ff @(posedge clk) begin
    if (issue) begin
      b1_sum.red   <= 12'(job.cs0.red)   + 12'(job.cs1.red)   + 12'(job.cs2.red);
      b1_sum.green <= 12'(job.cs0.green) + 12'(job.cs1.green) + 12'(job.cs2.green);
      b1_sum.blue  <= 12'(job.cs0.blue)  + 12'(job.cs1.blue)  + 12'(job.cs2.blue);
      b1_last      <= sel_last;
      unique case (kind)
        RES_INNER: begin
          b1_filt <= job.filt;
          b1_pix  <= job.pass_a;
          b1_col  <= job.col - POS_W'(1);
          b1_row  <= job.row - POS_W'(1);
        end
        RES_EDGE: begin
          b1_filt <= 1'b0;
          b1_pix  <= job.pix_b;
          b1_col  <= job.edge_col;
          b1_row  <= job.row - POS_W'(1);
        end
        default: begin
          b1_filt <= 1'b0;
          b1_pix  <= job.pix_c;
          b1_col  <= job.col;
          b1_row  <= job.row;
        end
      endcase
    end
  end

  // stage 2: divide by nine as a multiply by the scaled reciprocal
  always_ff @(posedge clk) begin
    if (b1_valid) begin
      b2_prod.red   <= 24'(b1_sum.red)   * 24'(RECIP9);
      b2_prod.green <= 24'(b1_sum.green) * 24'(RECIP9);
      b2_prod.blue  <= 24'(b1_sum.blue)  * 24'(RECIP9);
      b2_filt       <= b1_filt;
      b2_pix        <= b1_pix;
      b2_col        <= b1_col;
      b2_row        <= b1_row;
      b2_last       <= b1_last;
    end
  end

  always_comb begin
    if (b2_filt) begin
      of_word.red_out   = b2_prod.red[DIV9_SHIFT +: 8];
      of_word.green_out = b2_prod.green[DIV9_SHIFT +: 8];
      of_word.blue_out  = b2_prod.blue[DIV9_SHIFT +: 8];
    end else begin
      of_word.red_out   = b2_pix.red;
      of_word.green_out = b2_pix.green;
      of_word.blue_out  = b2_pix.blue;
    end
    of_word.out_column  = b2_col;
    of_word.out_row     = b2_row;
    of_word.last_of_run = b2_last;
  end

  assign empty  = (of_count == '0);
  assign result = of_slots[of_rd];
  assign of_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      of_wr    <= '0;
      of_rd    <= '0;
      of_count <= '0;
    end else begin
      if (b2_valid) begin
        of_wr <= of_wr + OW'(1);
      end
      if (of_pop) begin
        of_rd <= of_rd + OW'(1);
      end
      of_count <= of_count + (OW + 1)'(b2_valid) - (OW + 1)'(of_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b2_valid) begin
      of_slots[of_wr] <= of_word;
    end
  end

endmodule

// ===== rtl/box_filter_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_unit
// Streaming 3x3 mean filter on raster RGB pixels, border passed through.
//
//   channel   direction  handshake          payload
//   pixels    in         push / full        pixel_in  (in_item_t)
//   results   out        empty / pop        result    (out_item_t)
//   config    in         cfg_write          cfg_index, cfg_data
//
// While results are popped, one pixel is taken per cycle as long as each
// pixel causes at most one result; the output queue delivers one result per
// cycle, so at the right edge and on the bottom row (two or three results per
// pixel) intake slows to match. A result passes from its pixel through line
// store read, column sum and classification, window add, reciprocal multiply.
// Synchronous reset clears the counters and queues; the line store needs no
// clearing. full and empty depend only on registered state.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_unit
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  input  in_item_t   pixel_in,
  input  logic       push,
  output logic       full,
  output out_item_t  result,
  output logic       empty,
  input  logic       pop
);

  job_t jq_in;
  logic jq_push;
  logic jq_full;
  job_t jq_head;
  logic jq_pop;
  logic jq_empty;

  bf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .push      (push),
    .full      (full),
    .job       (jq_in),
    .job_push  (jq_push),
    .job_full  (jq_full)
  );

  bf3_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (jq_in),
    .wr_push  (jq_push),
    .wr_full  (jq_full),
    .rd_job   (jq_head),
    .rd_pop   (jq_pop),
    .rd_empty (jq_empty)
  );

  bf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (jq_head),
    .job_empty (jq_empty),
    .job_pop   (jq_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  a_job_has_result: assert property (@(posedge clk) disable iff (rst)
    jq_push |-> (jq_in.has_a || jq_in.has_b || jq_in.has_c))
    else $error("job queued with no result");

  a_edge_after_lag: assert property (@(posedge clk) disable iff (rst)
    (jq_push && jq_in.has_b) |-> jq_in.has_a)
    else $error("right edge result without lagging result");

  a_filter_interior: assert property (@(posedge clk) disable iff (rst)
    (jq_push && jq_in.filt) |-> (jq_in.has_a && jq_in.row >= POS_W'(KERNEL - 1)))
    else $error("mean requested outside the interior");

  a_empty_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> empty)
    else $error("results pending right after reset");

endmodule

// ===== bench/tb_box_filter_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_rgb_unit
// Self-checking bench for the streaming 3x3 RGB mean filter. Pixels go in
// through the push/full queue port in bursts. Results are taken through
// empty/pop while the receiver stalls on its own pattern. Each result is
// matched in order against a cycle-free model of the filter's line stores,
// window and frame counters. The run covers the reset size, a short table of
// fixed frames, the extreme and saturated sizes, and many small frames with
// random content and mid-frame restarts.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_rgb_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bf3_pkg::*;

  localparam int MAX_W    = 2048;
  localparam int SETTLE   = 16;     // cycles of pipeline drain past the last result
  localparam int SHOW_MAX = 50;

  typedef struct {
    logic       is_reg;
    cfg_index_t reg_idx;
    cfg_data_t  reg_val;
    pixel_t     pix;
    logic       has_want;
    out_item_t  want;
  } script_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  cfg_index_t cfg_index = REG_IMAGE_WIDTH;
  cfg_data_t  cfg_data = '0;
  in_item_t   pixel_in = '0;
  logic       push = 1'b0;
  logic       full;
  out_item_t  result;
  logic       empty;
  logic       pop = 1'b0;

  // filter model state
  cfg_data_t   size_w_reg = cfg_data_t'(RESET_WIDTH);
  cfg_data_t   size_h_reg = cfg_data_t'(RESET_HEIGHT);
  pixel_t      line_upper [MAX_W];
  pixel_t      line_lower [MAX_W];
  pixel_t      win [6];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  out_item_t   pending_results [$];
  script_row_t script [$];

  int mismatch_count  = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int burst_left      = 0;
  int pop_run_left    = 0;

  box_filter_3x3_rgb_unit #(.MAX_WIDTH(MAX_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel_in (pixel_in),
    .push     (push),
    .full     (full),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("box_filter_3x3_rgb_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOW_MAX) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned clamp_size(input cfg_data_t v, input int unsigned hi);
    if (v < KERNEL) return KERNEL;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic out_item_t make_result(input pixel_t p, input int unsigned col,
                                            input int unsigned row);
    out_item_t o;
    o.red_out     = p.red;
    o.green_out   = p.green;
    o.blue_out    = p.blue;
    o.out_column  = pos_t'(col);
    o.out_row     = pos_t'(row);
    o.last_of_run = 1'b0;
    return o;
  endfunction

  function automatic void set_size(input cfg_index_t idx, input cfg_data_t val);
    if (idx == REG_IMAGE_WIDTH) size_w_reg = val;
    else size_h_reg = val;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Queue the results one pixel causes and advance the model; return the last one.
  function automatic void filter_pixel(input pixel_t px, output out_item_t last_res);
    int unsigned w, h, c, r;
    pixel_t      top, mid, val;
    pixel_t      nb [9];
    out_item_t   res [3];
    int          n, rs, gs, bs;
    w = clamp_size(size_w_reg, MAX_W);
    h = clamp_size(size_h_reg, ROW_LIMIT);
    c = col_pos;
    r = row_pos;
    n = 0;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    top = line_upper[c];
    mid = line_lower[c];
    if (r >= 1 && c >= 1) begin
      if (c >= 2 && r >= 2) begin
        nb[0] = top;
        nb[1] = mid;
        nb[2] = px;
        for (int k = 0; k < 6; k++) nb[k+3] = win[k];
        rs = 0;
        gs = 0;
        bs = 0;
        for (int k = 0; k < 9; k++) begin
          rs += nb[k].red;
          gs += nb[k].green;
          bs += nb[k].blue;
        end
        val = {8'(rs / 9), 8'(gs / 9), 8'(bs / 9)};
      end else begin
        val = win[1];
      end
      res[n] = make_result(val, c - 1, r - 1);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      res[n] = make_result(mid, w - 1, r - 1);
      n++;
    end
    if (r == h - 1) begin
      res[n] = make_result(px, c, r);
      n++;
    end
    last_res = '0;
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) res[k].last_of_run = 1'b1;
      pending_results.push_back(res[k]);
      last_res = res[k];
    end
    line_upper[c] = mid;
    line_lower[c] = px;
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_channel();
    p.green = random_channel();
    p.blue  = random_channel();
    return p;
  endfunction

  // Insert a random gap at the start of each burst.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Hold push until the transfer, then update the model. push stays high.
  task automatic send_pixel(input pixel_t px, input logic has_want, input out_item_t want);
    out_item_t last_res;
    push     <= 1'b1;
    pixel_in <= in_item_t'(px);
    @(posedge clk);
    while (full) @(posedge clk);
    filter_pixel(px, last_res);
    pixels_sent++;
    if (has_want && last_res !== want)
      report_mismatch($sformatf("pixel %0d: last result %h, table gives %h",
                                pixels_sent, last_res, want));
  endtask

  task automatic send_stream(input int count);
    for (int i = 0; i < count; i++) begin
      pace();
      send_pixel(random_pixel(), 1'b0, '0);
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // cfg_write is left high; the caller drops it after the last write.
  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    set_size(idx, val);
  endtask

  task automatic write_sizes(input logic do_w, input cfg_data_t w_val,
                             input logic do_h, input cfg_data_t h_val);
    wait_idle();
    if (do_w) write_reg(REG_IMAGE_WIDTH, w_val);
    if (do_h) write_reg(REG_IMAGE_HEIGHT, h_val);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic add_reg(input cfg_index_t idx, input cfg_data_t val);
    script_row_t row;
    row          = '{default: '0};
    row.is_reg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    script.push_back(row);
  endtask

  task automatic add_pixel(input pixel_t px, input logic has_want, input out_item_t want);
    script_row_t row;
    row          = '{default: '0};
    row.pix      = px;
    row.has_want = has_want;
    row.want     = want;
    script.push_back(row);
  endtask

  // Receiver: runs of pops broken by short stalls.
  always @(posedge clk) begin
    if (pop_run_left > 0) begin
      pop_run_left <= pop_run_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      pop          <= 1'b0;
      pop_run_left <= $urandom_range(0, 6);
    end else begin
      pop          <= 1'b1;
      pop_run_left <= $urandom_range(0, 40);
    end
  end

  // Values seen here are the ones the next rising edge transfers.
  always @(negedge clk) begin
    out_item_t want;
    string     diff;
    if (!rst && pop && !empty) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", result));
      end else begin
        want = pending_results.pop_front();
        diff = "";
        if (result.red_out !== want.red_out) diff = {diff, " red"};
        if (result.green_out !== want.green_out) diff = {diff, " green"};
        if (result.blue_out !== want.blue_out) diff = {diff, " blue"};
        if (result.out_column !== want.out_column) diff = {diff, " column"};
        if (result.out_row !== want.out_row) diff = {diff, " row"};
        if (result.last_of_run !== want.last_of_run) diff = {diff, " last"};
        if (diff != "")
          report_mismatch($sformatf("result %0d (col %0d row %0d) differs in%s: got %h want %h",
                                    results_checked, want.out_column, want.out_row, diff,
                                    result, want));
      end
    end
  end

  initial begin
    pixel_t    white, tone_a, tone_b;
    out_item_t want;
    int        random_pixels, count, which;
    int unsigned area;
    cfg_data_t w_val, h_val;

    white  = 24'hffffff;
    tone_a = 24'hff0080;
    tone_b = 24'h00ff7f;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset size: start of the first row of a 640x480 frame
    send_stream(16);

    // 3x3 white frame: border passes, center mean of the maximum stays 255
    add_reg(REG_IMAGE_WIDTH, 12'd3);
    add_reg(REG_IMAGE_HEIGHT, 12'd3);
    for (int k = 0; k < 9; k++) begin
      want = '{8'hff, 8'hff, 8'hff, pos_t'((k == 8) ? 2 : 0), pos_t'((k == 4) ? 0 : 2), 1'b1};
      add_pixel(white, (k == 4 || k == 6 || k == 8), want);
    end
    // mixed frame for the mean of unequal channels
    for (int k = 0; k < 9; k++) add_pixel((k % 2) ? tone_b : tone_a, 1'b0, '0);
    // sizes below the kernel saturate to 3; a first row gives no results
    add_reg(REG_IMAGE_WIDTH, 12'd1);
    add_reg(REG_IMAGE_HEIGHT, 12'd2);
    add_pixel(tone_a, 1'b0, '0);
    add_pixel(white, 1'b0, '0);
    add_pixel(24'h000000, 1'b0, '0);

    for (int i = 0; i < script.size(); i++) begin
      if (script[i].is_reg) begin
        if (i == 0 || !script[i-1].is_reg) wait_idle();
        write_reg(script[i].reg_idx, script[i].reg_val);
        if (i == script.size() - 1 || !script[i+1].is_reg) cfg_write <= 1'b0;
      end else begin
        pace();
        send_pixel(script[i].pix, script[i].has_want, script[i].want);
      end
    end

    // first rows of the widest and of the tallest frames
    write_sizes(1'b1, 12'hfff, 1'b1, 12'd3);
    send_stream(24);
    write_sizes(1'b1, 12'd3, 1'b1, 12'hfff);
    send_stream(24);
    write_sizes(1'b1, 12'd0, 1'b1, 12'd0);
    send_stream(20);

    // small frames; partial frames restart on the next write
    random_pixels = 0;
    while (random_pixels < 150) begin
      which = (random_pixels == 0) ? 0 : $urandom_range(0, 2);
      w_val = ($urandom_range(0, 5) == 0) ? cfg_data_t'($urandom_range(0, 2))
                                          : cfg_data_t'($urandom_range(3, 16));
      h_val = ($urandom_range(0, 5) == 0) ? cfg_data_t'($urandom_range(0, 2))
                                          : cfg_data_t'($urandom_range(3, 8));
      write_sizes(which != 2, w_val, which != 1, h_val);
      area  = clamp_size(size_w_reg, MAX_W) * clamp_size(size_h_reg, ROW_LIMIT);
      count = $urandom_range(1, 2 * area + 2);
      if (count > 40) count = 40;
      send_stream(count);
      random_pixels += count;
    end

    wait_idle();
    $display("Run: %0d pixels in, %0d results checked, %0d size settings after reset",
             pixels_sent, results_checked, settings_used);
    $display("Sizes from below the kernel to the widest and tallest, small frames wrap and restart");
    if (mismatch_count == 0) begin
      $display("box_filter_3x3_rgb_unit test passed");
    end else begin
      $display("box_filter_3x3_rgb_unit test failed");
    end
    $finish;
  end

endmodule
